[hdl/bilinear_plasticity_return_map_top_macros.svh]
// assertion macros for the bilinear plasticity return map checker
`ifndef BILINEAR_PLASTICITY_RETURN_MAP_TOP_MACROS_SVH
`define BILINEAR_PLASTICITY_RETURN_MAP_TOP_MACROS_SVH

// same-cycle implication
`define BPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bpr_pkg.sv]
// shared types, codes and saturation helpers for the bilinear plasticity return map
package bpr_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned MOD_W   = 31;
  localparam int unsigned RATIO_W = 21;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
  localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

  typedef enum logic [1:0] {
    OP_TRIAL  = 2'd0,
    OP_COMMIT = 2'd1,
    OP_REVERT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELASTIC   = 3'd0,
    CFG_YIELD     = 3'd1,
    CFG_HARD_FRAC = 3'd2,
    CFG_KIN_SHARE = 3'd3,
    CFG_HARD_MOD  = 3'd4,
    CFG_INV_MOD   = 3'd5,
    CFG_TOL       = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INCR,
    ST_MUL0,
    ST_STRESS,
    ST_SHIFT,
    ST_MAG,
    ST_FUNC,
    ST_CHECK,
    ST_DP,
    ST_TAN,
    ST_CORR,
    ST_BH,
    ST_BH2,
    ST_BACK,
    ST_FIN,
    ST_MISC
  } step_e;

  typedef enum logic [3:0] {
    MS_NONE,
    MS_E_INCR,
    MS_ONE_HP,
    MS_HARD_PL,
    MS_F_INV,
    MS_E_H,
    MS_E_DP,
    MS_BETA_HP,
    MS_T2_DP
  } mul_sel_e;

  typedef struct packed {
    step_e    step;
    mul_sel_e mul_sel;
    logic     mul_en;
    logic     load_out;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic op_trial;
    logic incr_zero;
    logic yield_hit;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [31:0] total_strain;
  } in_t;

  typedef struct packed {
    logic signed [31:0] stress_out;
    logic [30:0]        tangent_out;
    logic               yielded;
    logic               saturated;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] res;
    if (v > SAT_HI) begin
      res = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic clip32(input logic signed [33:0] v);
    return (v > SAT_HI) || (v < SAT_LO);
  endfunction

endpackage

[hdl/bpr_mul.sv]
// shared signed multiplier with registered product and saturating fixed point rescale
module bpr_mul #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] res_o,
  output logic               clip_o
);

  localparam logic signed [63:0] HI64 = 64'sd2147483647;
  localparam logic signed [63:0] LO64 = -64'sd2147483648;

  logic signed [63:0] prod_q;
  logic signed [63:0] scaled;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 64'(a_i) * 64'(b_i);
    end
  end

  // arithmetic shift rounds toward minus infinity
  always_comb begin
    scaled = prod_q >>> FRAC_BITS;
    if (scaled > HI64) begin
      res_o  = 32'sh7fffffff;
      clip_o = 1'b1;
    end else if (scaled < LO64) begin
      res_o  = 32'sh80000000;
      clip_o = 1'b1;
    end else begin
      res_o  = scaled[31:0];
      clip_o = 1'b0;
    end
  end

endmodule

[hdl/bpr_seq.sv]
// sequencer that steps one transaction through the shared multiplier
module bpr_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bpr_pkg::stat_t stat_i,
  output bpr_pkg::ctl_t  ctl_o
);

  bpr_pkg::step_e state_q;
  bpr_pkg::step_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    ctl_o.step     = state_q;
    ctl_o.mul_sel  = bpr_pkg::MS_NONE;
    ctl_o.load_out = 1'b0;
    unique case (state_q)
      bpr_pkg::ST_IDLE: begin
        if (stat_i.start) begin
          state_d = stat_i.op_trial ? bpr_pkg::ST_INCR : bpr_pkg::ST_MISC;
        end
      end
      bpr_pkg::ST_INCR: begin
        state_d = stat_i.incr_zero ? bpr_pkg::ST_FIN : bpr_pkg::ST_MUL0;
      end
      bpr_pkg::ST_MUL0: begin
        ctl_o.mul_sel = bpr_pkg::MS_E_INCR;
        state_d       = bpr_pkg::ST_STRESS;
      end
      bpr_pkg::ST_STRESS: begin
        ctl_o.mul_sel = bpr_pkg::MS_ONE_HP;
        state_d       = bpr_pkg::ST_SHIFT;
      end
      bpr_pkg::ST_SHIFT: begin
        state_d = bpr_pkg::ST_MAG;
      end
      bpr_pkg::ST_MAG: begin
        ctl_o.mul_sel = bpr_pkg::MS_HARD_PL;
        state_d       = bpr_pkg::ST_FUNC;
      end
      bpr_pkg::ST_FUNC: begin
        state_d = bpr_pkg::ST_CHECK;
      end
      bpr_pkg::ST_CHECK: begin
        if (stat_i.yield_hit) begin
          ctl_o.mul_sel = bpr_pkg::MS_F_INV;
          state_d       = bpr_pkg::ST_DP;
        end else begin
          state_d = bpr_pkg::ST_FIN;
        end
      end
      bpr_pkg::ST_DP: begin
        ctl_o.mul_sel = bpr_pkg::MS_E_H;
        state_d       = bpr_pkg::ST_TAN;
      end
      bpr_pkg::ST_TAN: begin
        ctl_o.mul_sel = bpr_pkg::MS_E_DP;
        state_d       = bpr_pkg::ST_CORR;
      end
      bpr_pkg::ST_CORR: begin
        ctl_o.mul_sel = bpr_pkg::MS_BETA_HP;
        state_d       = bpr_pkg::ST_BH;
      end
      bpr_pkg::ST_BH: begin
        state_d = bpr_pkg::ST_BH2;
      end
      bpr_pkg::ST_BH2: begin
        ctl_o.mul_sel = bpr_pkg::MS_T2_DP;
        state_d       = bpr_pkg::ST_BACK;
      end
      bpr_pkg::ST_BACK: begin
        state_d = bpr_pkg::ST_FIN;
      end
      bpr_pkg::ST_FIN, bpr_pkg::ST_MISC: begin
        if (stat_i.out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = bpr_pkg::ST_IDLE;
        end
      end
    endcase
    ctl_o.mul_en = (ctl_o.mul_sel != bpr_pkg::MS_NONE);
  end

endmodule

[hdl/bilinear_plasticity_return_map_top.sv]
// Bilinear elastoplastic material point with mixed hardening, one transaction at a time.
// A trial update ends after the yield check when it passes and goes on through a return
// map when it does not; a trial update with zero strain increment skips straight to the
// result, and commit, revert and clear go straight to it from idle. The single 32x32
// signed multiplier is shared by every product of the update in turn; each product is
// registered, then rescaled and saturated before it is accumulated or stored. The result
// register lets the block take the next transaction while a result still waits downstream.
module bilinear_plasticity_return_map_top #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bpr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bpr_pkg::MOD_W-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  bpr_pkg::in_t                         in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output bpr_pkg::out_t                        out_data_o
);

  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

  // configuration
  logic [30:0] e_q, y_q, hp_q, inv_q, tol_q;
  logic [20:0] h_q, beta_q;

  // architectural state
  logic signed [31:0] cstrain_q, cstress_q, cback_q, cplas_q;
  logic [30:0]        ctan_q;
  logic signed [31:0] tstrain_q, tstress_q, tback_q, tplas_q;
  logic [30:0]        ttan_q;

  // work registers
  logic [1:0]         op_q;
  logic signed [31:0] strain_q, incr_q, stress_q, shifted_q, mag_q, hard_q, f_q, dp_q;
  logic               yld_q, sat_q, out_valid_q;
  bpr_pkg::out_t      out_q;

  bpr_pkg::ctl_t  ctl;
  bpr_pkg::stat_t stat;

  logic signed [31:0] e_s, y_s, h_s, beta_s, hp_s, inv_s;
  logic signed [31:0] mul_a, mul_b, mul_res;
  logic               mul_clip;
  logic signed [33:0] incr_w, stress_w, shift_w, mag_w, f_w, corr_w, back_w, plas_w;
  logic               sgn_pos, sgn_neg, start;
  logic signed [31:0] misc_stress;
  logic [30:0]        misc_tan;

  assign e_s    = signed'({1'b0, e_q});
  assign y_s    = signed'({1'b0, y_q});
  assign hp_s   = signed'({1'b0, hp_q});
  assign inv_s  = signed'({1'b0, inv_q});
  assign h_s    = signed'({11'b0, h_q});
  assign beta_s = signed'({11'b0, beta_q});

  assign in_stall_o  = (ctl.step != bpr_pkg::ST_IDLE);
  assign start       = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat.start     = start;
  assign stat.op_trial  = (in_data_i.opcode == bpr_pkg::OP_TRIAL);
  assign stat.incr_zero = (incr_w == 34'sd0);
  assign stat.yield_hit = (33'(f_q) > signed'({2'b0, tol_q}));
  assign stat.out_free  = !out_valid_q || !out_stall_i;

  bpr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  always_comb begin
    unique case (ctl.mul_sel)
      bpr_pkg::MS_E_INCR:  begin mul_a = e_s;             mul_b = incr_q;  end
      bpr_pkg::MS_ONE_HP:  begin mul_a = ONE_FX - beta_s; mul_b = hp_s;    end
      bpr_pkg::MS_HARD_PL: begin mul_a = hard_q;          mul_b = cplas_q; end
      bpr_pkg::MS_F_INV:   begin mul_a = f_q;             mul_b = inv_s;   end
      bpr_pkg::MS_E_H:     begin mul_a = e_s;             mul_b = h_s;     end
      bpr_pkg::MS_E_DP:    begin mul_a = e_s;             mul_b = dp_q;    end
      bpr_pkg::MS_BETA_HP: begin mul_a = beta_s;          mul_b = hp_s;    end
      bpr_pkg::MS_T2_DP:   begin mul_a = hard_q;          mul_b = dp_q;    end
      default:             begin mul_a = '0;              mul_b = '0;      end
    endcase
  end

  bpr_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (ctl.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .res_o  (mul_res),
    .clip_o (mul_clip)
  );

  always_comb begin
    sgn_pos  = !shifted_q[31] && (shifted_q != 32'sd0);
    sgn_neg  = shifted_q[31];
    incr_w   = 34'(strain_q) - 34'(cstrain_q);
    stress_w = 34'(cstress_q) + 34'(mul_res);
    shift_w  = 34'(stress_q) - 34'(cback_q);
    mag_w    = shifted_q[31] ? -34'(shifted_q) : 34'(shifted_q);
    f_w      = 34'(mag_q) - 34'(y_s) - 34'(mul_res);
    plas_w   = 34'(cplas_q) + 34'(dp_q);
    if (sgn_pos) begin
      corr_w = 34'(stress_q) - 34'(mul_res);
      back_w = 34'(cback_q) + 34'(mul_res);
    end else if (sgn_neg) begin
      corr_w = 34'(stress_q) + 34'(mul_res);
      back_w = 34'(cback_q) - 34'(mul_res);
    end else begin
      corr_w = 34'(stress_q);
      back_w = 34'(cback_q);
    end
    unique case (op_q)
      bpr_pkg::OP_COMMIT: begin misc_stress = tstress_q; misc_tan = ttan_q; end
      bpr_pkg::OP_REVERT: begin misc_stress = cstress_q; misc_tan = ctan_q; end
      bpr_pkg::OP_CLEAR:  begin misc_stress = '0;        misc_tan = e_q;    end
      default:            begin misc_stress = tstress_q; misc_tan = ttan_q; end
    endcase
  end

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q    <= '0;
      y_q    <= '0;
      h_q    <= '0;
      beta_q <= '0;
      hp_q   <= '0;
      inv_q  <= '0;
      tol_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpr_pkg::CFG_ELASTIC:   e_q    <= cfg_wdata_i;
        bpr_pkg::CFG_YIELD:     y_q    <= cfg_wdata_i;
        bpr_pkg::CFG_HARD_FRAC: h_q    <= cfg_wdata_i[20:0];
        bpr_pkg::CFG_KIN_SHARE: beta_q <= cfg_wdata_i[20:0];
        bpr_pkg::CFG_HARD_MOD:  hp_q   <= cfg_wdata_i;
        bpr_pkg::CFG_INV_MOD:   inv_q  <= cfg_wdata_i;
        bpr_pkg::CFG_TOL:       tol_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // material state and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cstrain_q   <= '0;
      cstress_q   <= '0;
      cback_q     <= '0;
      cplas_q     <= '0;
      ctan_q      <= '0;
      tstrain_q   <= '0;
      tstress_q   <= '0;
      tback_q     <= '0;
      tplas_q     <= '0;
      ttan_q      <= '0;
      yld_q       <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctl.load_out) begin
        out_valid_q <= 1'b1;
      end
      unique case (ctl.step)
        bpr_pkg::ST_IDLE: begin
          if (start) begin
            yld_q <= 1'b0;
            sat_q <= 1'b0;
          end
        end
        bpr_pkg::ST_INCR: begin
          tstrain_q <= strain_q;
          if (incr_w != 34'sd0) begin
            sat_q   <= bpr_pkg::clip32(incr_w);
            tback_q <= cback_q;
            tplas_q <= cplas_q;
            ttan_q  <= e_q;
          end
        end
        bpr_pkg::ST_STRESS: sat_q <= sat_q | mul_clip | bpr_pkg::clip32(stress_w);
        bpr_pkg::ST_SHIFT:  sat_q <= sat_q | mul_clip | bpr_pkg::clip32(shift_w);
        bpr_pkg::ST_MAG:    sat_q <= sat_q | bpr_pkg::clip32(mag_w);
        bpr_pkg::ST_FUNC:   sat_q <= sat_q | mul_clip | bpr_pkg::clip32(f_w);
        bpr_pkg::ST_CHECK: begin
          if (stat.yield_hit) begin
            yld_q <= 1'b1;
          end
        end
        bpr_pkg::ST_DP:     sat_q <= sat_q | mul_clip;
        bpr_pkg::ST_TAN: begin
          sat_q  <= sat_q | mul_clip;
          ttan_q <= mul_res[30:0];
        end
        bpr_pkg::ST_CORR:   sat_q <= sat_q | mul_clip | bpr_pkg::clip32(corr_w);
        bpr_pkg::ST_BH: begin
          sat_q   <= sat_q | mul_clip | bpr_pkg::clip32(plas_w);
          tplas_q <= bpr_pkg::sat32(plas_w);
        end
        bpr_pkg::ST_BH2: ;
        bpr_pkg::ST_BACK: begin
          sat_q   <= sat_q | mul_clip | bpr_pkg::clip32(back_w);
          tback_q <= bpr_pkg::sat32(back_w);
        end
        bpr_pkg::ST_FIN: begin
          if (ctl.load_out) begin
            tstress_q <= stress_q;
          end
        end
        bpr_pkg::ST_MISC: begin
          if (ctl.load_out) begin
            unique case (op_q)
              bpr_pkg::OP_COMMIT: begin
                cstrain_q <= tstrain_q;
                cstress_q <= tstress_q;
                ctan_q    <= ttan_q;
                cback_q   <= tback_q;
                cplas_q   <= tplas_q;
              end
              bpr_pkg::OP_REVERT: begin
                tstrain_q <= cstrain_q;
                tstress_q <= cstress_q;
                ttan_q    <= ctan_q;
                tback_q   <= cback_q;
                tplas_q   <= cplas_q;
              end
              bpr_pkg::OP_CLEAR: begin
                cstrain_q <= '0;
                cstress_q <= '0;
                cback_q   <= '0;
                cplas_q   <= '0;
                ctan_q    <= e_q;
                tstrain_q <= '0;
                tstress_q <= '0;
                tback_q   <= '0;
                tplas_q   <= '0;
                ttan_q    <= e_q;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // work registers and result payload
  always_ff @(posedge clk_i) begin
    if (start) begin
      op_q     <= in_data_i.opcode;
      strain_q <= in_data_i.total_strain;
    end
    unique case (ctl.step)
      bpr_pkg::ST_INCR: begin
        incr_q   <= bpr_pkg::sat32(incr_w);
        stress_q <= tstress_q;
      end
      bpr_pkg::ST_STRESS: stress_q  <= bpr_pkg::sat32(stress_w);
      bpr_pkg::ST_SHIFT: begin
        hard_q    <= mul_res;
        shifted_q <= bpr_pkg::sat32(shift_w);
      end
      bpr_pkg::ST_MAG:    mag_q     <= bpr_pkg::sat32(mag_w);
      bpr_pkg::ST_FUNC:   f_q       <= bpr_pkg::sat32(f_w);
      bpr_pkg::ST_DP:     dp_q      <= mul_res;
      bpr_pkg::ST_CORR:   stress_q  <= bpr_pkg::sat32(corr_w);
      bpr_pkg::ST_BH:     hard_q    <= mul_res;
      default: ;
    endcase
    if (ctl.load_out) begin
      if (ctl.step == bpr_pkg::ST_MISC) begin
        out_q.stress_out  <= misc_stress;
        out_q.tangent_out <= misc_tan;
      end else begin
        out_q.stress_out  <= stress_q;
        out_q.tangent_out <= ttan_q;
      end
      out_q.yielded   <= yld_q;
      out_q.saturated <= sat_q;
    end
  end

endmodule

[hdl/bpr_chk.sv]
// port-level checker for the bilinear plasticity return map, bound to the top level
`include "bilinear_plasticity_return_map_top_macros.svh"

module bpr_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bpr_pkg::out_t out_data_o
);

  // stalled result holds
  `BPR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // an accepted transaction occupies the block
  `BPR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after transaction accepted")

  // a new result only comes out of a busy cycle
  `BPR_ASSERT_NOW(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result appeared without work in progress")

endmodule

bind bilinear_plasticity_return_map_top bpr_chk u_bpr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
